[design/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg
// Shared constants and types for the closest-point-on-segment core.
// ----------------------------------------------------------------------------
package cps_pkg;

    // fraction bits of the projection ratio b
    localparam int B_FRAC = 24;

    localparam int DEF_COORD_WIDTH = 24;

    typedef enum logic [1:0] {
        CASE_INTERIOR = 2'd0,
        CASE_FIRST    = 2'd1,
        CASE_SECOND   = 2'd2
    } clamp_case_t;

endpackage

[design/cps_front.sv]
// ----------------------------------------------------------------------------
// cps_front
// Three front stages: difference vectors, products, dot products and clamp
// classification.
// ----------------------------------------------------------------------------
module cps_front import cps_pkg::*; #(
    parameter int CW = DEF_COORD_WIDTH
) (
    input  logic                 aclk,
    input  logic [2:0]           en,
    input  logic signed [CW-1:0] p1x,
    input  logic signed [CW-1:0] p1y,
    input  logic signed [CW-1:0] p2x,
    input  logic signed [CW-1:0] p2y,
    input  logic signed [CW-1:0] qx,
    input  logic signed [CW-1:0] qy,
    output logic signed [CW-1:0] p1x_reg,
    output logic signed [CW-1:0] p1y_reg,
    output logic signed [CW:0]   vx_reg,
    output logic signed [CW:0]   vy_reg,
    output clamp_case_t          case_reg,
    output logic [2*CW+1:0]      rem_reg,
    output logic [2*CW+1:0]      c2_reg
);
    localparam int DW = 2*CW + 2;

    logic signed [CW-1:0] a_p1x_reg, a_p1y_reg, b_p1x_reg, b_p1y_reg;
    logic signed [CW:0]   a_vx_reg, a_vy_reg, a_wx_reg, a_wy_reg;
    logic signed [CW:0]   b_vx_reg, b_vy_reg;
    logic signed [DW-1:0] wvx_reg, wvy_reg, vvx_reg, vvy_reg;
    logic signed [DW:0]   c1;
    logic [DW-1:0]        c2;
    clamp_case_t          case_next;

    always_comb begin
        c1 = (DW+1)'(wvx_reg) + (DW+1)'(wvy_reg);
        c2 = vvx_reg + vvy_reg;
        if (c1[DW] || c1 == '0) begin
            case_next = CASE_FIRST;
        end else if ({1'b0, c2} <= c1) begin
            case_next = CASE_SECOND;
        end else begin
            case_next = CASE_INTERIOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_p1x_reg <= p1x;
            a_p1y_reg <= p1y;
            a_vx_reg  <= (CW+1)'(p2x) - (CW+1)'(p1x);
            a_vy_reg  <= (CW+1)'(p2y) - (CW+1)'(p1y);
            a_wx_reg  <= (CW+1)'(qx) - (CW+1)'(p1x);
            a_wy_reg  <= (CW+1)'(qy) - (CW+1)'(p1y);
        end
        if (en[1]) begin
            b_p1x_reg <= a_p1x_reg;
            b_p1y_reg <= a_p1y_reg;
            b_vx_reg  <= a_vx_reg;
            b_vy_reg  <= a_vy_reg;
            wvx_reg   <= DW'(a_wx_reg) * DW'(a_vx_reg);
            wvy_reg   <= DW'(a_wy_reg) * DW'(a_vy_reg);
            vvx_reg   <= DW'(a_vx_reg) * DW'(a_vx_reg);
            vvy_reg   <= DW'(a_vy_reg) * DW'(a_vy_reg);
        end
        if (en[2]) begin
            p1x_reg  <= b_p1x_reg;
            p1y_reg  <= b_p1y_reg;
            vx_reg   <= b_vx_reg;
            vy_reg   <= b_vy_reg;
            case_reg <= case_next;
            rem_reg  <= c1[DW-1:0];
            c2_reg   <= c2;
        end
    end

endmodule

[design/cps_cell.sv]
// ----------------------------------------------------------------------------
// cps_cell
// One chain cell: one restoring division bit of c1/c2 (when DO_DIV) and one
// bit of the integer square root of c2 (when DO_SQRT), with the item's payload handed on.
// ----------------------------------------------------------------------------
module cps_cell import cps_pkg::*; #(
    parameter int CW      = DEF_COORD_WIDTH,
    parameter bit DO_DIV  = 1'b1,
    parameter bit DO_SQRT = 1'b1
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] p1x_in,
    input  logic signed [CW-1:0] p1y_in,
    input  logic signed [CW:0]   vx_in,
    input  logic signed [CW:0]   vy_in,
    input  clamp_case_t          case_in,
    input  logic [2*CW+1:0]      rem_in,
    input  logic [2*CW+1:0]      c2_in,
    input  logic [B_FRAC-1:0]    b_in,
    input  logic [CW+3:0]        srem_in,
    input  logic [CW:0]          root_in,
    input  logic [2*CW+1:0]      sval_in,
    output logic signed [CW-1:0] p1x_reg,
    output logic signed [CW-1:0] p1y_reg,
    output logic signed [CW:0]   vx_reg,
    output logic signed [CW:0]   vy_reg,
    output clamp_case_t          case_reg,
    output logic [2*CW+1:0]      rem_reg,
    output logic [2*CW+1:0]      c2_reg,
    output logic [B_FRAC-1:0]    b_reg,
    output logic [CW+3:0]        srem_reg,
    output logic [CW:0]          root_reg,
    output logic [2*CW+1:0]      sval_reg
);
    localparam int DW  = 2*CW + 2;
    localparam int R   = CW + 1;
    localparam int SRW = R + 3;

    logic [DW-1:0]     sh, rem_next, sval_next;
    logic              dge, sge;
    logic [B_FRAC-1:0] b_next;
    logic [SRW-1:0]    shs, trial, srem_next;
    logic [R-1:0]      root_next;

    always_comb begin
        sh    = {rem_in[DW-2:0], 1'b0};
        dge   = (sh >= c2_in);
        shs   = {srem_in[SRW-3:0], sval_in[DW-1 -: 2]};
        trial = {1'b0, root_in, 2'b01};
        sge   = (shs >= trial);
        if (DO_DIV) begin
            rem_next = dge ? sh - c2_in : sh;
            b_next   = {b_in[B_FRAC-2:0], dge};
        end else begin
            rem_next = rem_in;
            b_next   = b_in;
        end
        if (DO_SQRT) begin
            srem_next = sge ? shs - trial : shs;
            root_next = {root_in[R-2:0], sge};
            sval_next = {sval_in[DW-3:0], 2'b00};
        end else begin
            srem_next = srem_in;
            root_next = root_in;
            sval_next = sval_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1x_reg  <= p1x_in;
            p1y_reg  <= p1y_in;
            vx_reg   <= vx_in;
            vy_reg   <= vy_in;
            case_reg <= case_in;
            rem_reg  <= rem_next;
            c2_reg   <= c2_in;
            b_reg    <= b_next;
            srem_reg <= srem_next;
            root_reg <= root_next;
            sval_reg <= sval_next;
        end
    end

endmodule

[design/cps_back.sv]
// ----------------------------------------------------------------------------
// cps_back
// Two back stages: scale vector and root by b, then round, add and select
// the clamped result.
// ----------------------------------------------------------------------------
module cps_back import cps_pkg::*; #(
    parameter int CW = DEF_COORD_WIDTH
) (
    input  logic                 aclk,
    input  logic [1:0]           en,
    input  logic signed [CW-1:0] p1x,
    input  logic signed [CW-1:0] p1y,
    input  logic signed [CW:0]   vx,
    input  logic signed [CW:0]   vy,
    input  clamp_case_t          case_in,
    input  logic [B_FRAC-1:0]    b,
    input  logic [CW:0]          root,
    output logic [CW-1:0]        nx_reg,
    output logic [CW-1:0]        ny_reg,
    output logic [CW:0]          off_reg,
    output clamp_case_t          case_reg
);
    localparam int PW = B_FRAC + CW;
    localparam int OW = B_FRAC + CW + 1;

    logic [CW:0]          avx, avy;
    logic [PW-1:0]        mx_reg, my_reg, rx, ry;
    logic [OW-1:0]        mo_reg;
    logic                 negx_reg, negy_reg;
    logic [CW-1:0]        ap1x_reg, ap1y_reg, avx_reg, avy_reg;
    logic [CW:0]          aroot_reg;
    clamp_case_t          acase_reg;
    logic [CW-1:0]        dx, dy;

    always_comb begin
        avx = vx[CW] ? -vx : vx;
        avy = vy[CW] ? -vy : vy;
        // negative scale rounds toward minus infinity
        rx = mx_reg + PW'({B_FRAC{1'b1}});
        ry = my_reg + PW'({B_FRAC{1'b1}});
        dx = negx_reg ? -rx[PW-1:B_FRAC] : mx_reg[PW-1:B_FRAC];
        dy = negy_reg ? -ry[PW-1:B_FRAC] : my_reg[PW-1:B_FRAC];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mx_reg    <= PW'(b) * PW'(avx[CW-1:0]);
            my_reg    <= PW'(b) * PW'(avy[CW-1:0]);
            mo_reg    <= OW'(b) * OW'(root);
            negx_reg  <= vx[CW];
            negy_reg  <= vy[CW];
            ap1x_reg  <= p1x;
            ap1y_reg  <= p1y;
            avx_reg   <= vx[CW-1:0];
            avy_reg   <= vy[CW-1:0];
            aroot_reg <= root;
            acase_reg <= case_in;
        end
        if (en[1]) begin
            case_reg <= acase_reg;
            case (acase_reg)
                CASE_FIRST: begin
                    nx_reg  <= ap1x_reg;
                    ny_reg  <= ap1y_reg;
                    off_reg <= '0;
                end
                CASE_SECOND: begin
                    nx_reg  <= ap1x_reg + avx_reg;
                    ny_reg  <= ap1y_reg + avy_reg;
                    off_reg <= aroot_reg;
                end
                default: begin
                    nx_reg  <= ap1x_reg + dx;
                    ny_reg  <= ap1y_reg + dy;
                    off_reg <= mo_reg[OW-1:B_FRAC];
                end
            endcase
        end
    end

endmodule

[design/closest_point_on_segment_core.sv]
// ----------------------------------------------------------------------------
// closest_point_on_segment_core
// Projects a query point onto a segment, clamped to the end points.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per query, carrying the segment end points
//   and the query point (signed fixed point). m_ channel: one transaction per
//   query with the nearest point, the distance along the segment and, on
//   m_tuser, the clamp case (0 interior, 1 first point, 2 second point).
//   Results come back in input order.
//   Stages: 3 front stages, max(24, COORD_WIDTH+1) chain cells (the first 24
//   each form one quotient bit, the first COORD_WIDTH+1 each one square root
//   bit), 2 back stages; s_ acceptance reaches m_tvalid through all of them.
//   Throughput: one transaction per cycle while m_tready does not hold the flow; every stage has its own valid.
//   When m_tready is low, stages fill up behind the output register and
//   s_tready drops only once every stage holds an item.
//   Reset (aresetn low, synchronous) empties the pipeline; no data is kept.
// ----------------------------------------------------------------------------
module closest_point_on_segment_core import cps_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // nearest_x, nearest_y, along_offset
    output logic [((3*COORD_WIDTH+1+7)/8)*8-1:0]     m_tdata,
    // clamp_case
    output logic [1:0]                               m_tuser
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = 2*CW + 2;
    localparam int R     = CW + 1;
    localparam int NCELL = (B_FRAC > R) ? B_FRAC : R;
    localparam int NSTG  = NCELL + 5;
    localparam int MW    = ((3*CW+1+7)/8)*8;

    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG:0]   rdy;

    always_comb begin
        rdy[NSTG] = m_tready;
        for (int i = NSTG-1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NSTG; i++) begin
            if (rdy[i]) begin
                vld_next[i] = (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    logic signed [CW-1:0] p1x [NCELL+1];
    logic signed [CW-1:0] p1y [NCELL+1];
    logic signed [CW:0]   vx  [NCELL+1];
    logic signed [CW:0]   vy  [NCELL+1];
    clamp_case_t          cs  [NCELL+1];
    logic [DW-1:0]        rem [NCELL+1];
    logic [DW-1:0]        c2  [NCELL+1];
    logic [B_FRAC-1:0]    bq  [NCELL+1];
    logic [R+2:0]         srem[NCELL+1];
    logic [R-1:0]         root[NCELL+1];
    logic [DW-1:0]        sval[NCELL+1];

    cps_front #(.CW(CW)) u_front (
        .aclk     (aclk),
        .en       (rdy[2:0]),
        .p1x      (s_tdata[CW-1:0]),
        .p1y      (s_tdata[2*CW-1:CW]),
        .p2x      (s_tdata[3*CW-1:2*CW]),
        .p2y      (s_tdata[4*CW-1:3*CW]),
        .qx       (s_tdata[5*CW-1:4*CW]),
        .qy       (s_tdata[6*CW-1:5*CW]),
        .p1x_reg  (p1x[0]),
        .p1y_reg  (p1y[0]),
        .vx_reg   (vx[0]),
        .vy_reg   (vy[0]),
        .case_reg (cs[0]),
        .rem_reg  (rem[0]),
        .c2_reg   (c2[0])
    );

    assign bq[0]   = '0;
    assign srem[0] = '0;
    assign root[0] = '0;
    assign sval[0] = c2[0];

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cps_cell #(
            .CW      (CW),
            .DO_DIV  (g < B_FRAC),
            .DO_SQRT (g < R)
        ) u_cell (
            .aclk     (aclk),
            .en       (rdy[g+3]),
            .p1x_in   (p1x[g]),
            .p1y_in   (p1y[g]),
            .vx_in    (vx[g]),
            .vy_in    (vy[g]),
            .case_in  (cs[g]),
            .rem_in   (rem[g]),
            .c2_in    (c2[g]),
            .b_in     (bq[g]),
            .srem_in  (srem[g]),
            .root_in  (root[g]),
            .sval_in  (sval[g]),
            .p1x_reg  (p1x[g+1]),
            .p1y_reg  (p1y[g+1]),
            .vx_reg   (vx[g+1]),
            .vy_reg   (vy[g+1]),
            .case_reg (cs[g+1]),
            .rem_reg  (rem[g+1]),
            .c2_reg   (c2[g+1]),
            .b_reg    (bq[g+1]),
            .srem_reg (srem[g+1]),
            .root_reg (root[g+1]),
            .sval_reg (sval[g+1])
        );
    end

    logic [CW-1:0] nx, ny;
    logic [CW:0]   off;
    clamp_case_t   ocase;

    cps_back #(.CW(CW)) u_back (
        .aclk     (aclk),
        .en       (rdy[NSTG-1:NSTG-2]),
        .p1x      (p1x[NCELL]),
        .p1y      (p1y[NCELL]),
        .vx       (vx[NCELL]),
        .vy       (vy[NCELL]),
        .case_in  (cs[NCELL]),
        .b        (bq[NCELL]),
        .root     (root[NCELL]),
        .nx_reg   (nx),
        .ny_reg   (ny),
        .off_reg  (off),
        .case_reg (ocase)
    );

    assign m_tdata = MW'({off, ny, nx});
    assign m_tuser = ocase;

    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ocase == CASE_FIRST |-> off == '0)
        else $error("first-point clamp with nonzero offset");

    a_case_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ocase == CASE_INTERIOR || ocase == CASE_FIRST ||
                      ocase == CASE_SECOND))
        else $error("illegal clamp case at output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_tready)
        else $error("input stalled with empty first stage");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Closest-point-on-segment core testbench: directed corner cases and random
// segment queries go through the stream input. An exact-arithmetic projection
// model predicts each result, and the results are checked in order under
// random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cps_pkg::*;

    localparam int CW = 24;
    localparam int IN_W = ((6*CW+7)/8)*8;
    localparam int OUT_W = ((3*CW+1+7)/8)*8;
    localparam int LATENCY = CW + 6;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW:0]   offset;
        clamp_case_t   ccase;
    } nearest_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    nearest_t nearest_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    closest_point_on_segment_core #(.COORD_WIDTH(CW)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // floor square root of a value below 2^50
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 25; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic nearest_t project(input logic signed [CW-1:0] p1x,
                                         input logic signed [CW-1:0] p1y,
                                         input logic signed [CW-1:0] p2x,
                                         input logic signed [CW-1:0] p2y,
                                         input logic signed [CW-1:0] qx,
                                         input logic signed [CW-1:0] qy);
        nearest_t r;
        longint vx, vy, wx, wy, dot, len2;
        longint unsigned ratio, root;
        logic signed [127:0] sx, sy;
        vx = longint'(p2x) - longint'(p1x);
        vy = longint'(p2y) - longint'(p1y);
        wx = longint'(qx) - longint'(p1x);
        wy = longint'(qy) - longint'(p1y);
        // each product < 2^50, sums fit 64 bits
        dot = wx * vx + wy * vy;
        len2 = vx * vx + vy * vy;
        if (dot <= 0) begin
            r.x = p1x; r.y = p1y; r.offset = '0; r.ccase = CASE_FIRST;
        end else if (len2 <= dot) begin
            r.x = p2x; r.y = p2y;
            r.offset = (CW+1)'(root_floor(len2));
            r.ccase = CASE_SECOND;
        end else begin
            ratio = 64'((128'(dot) << B_FRAC) / 128'(len2));
            root = root_floor(len2);
            sx = (128'(signed'(vx)) * 128'(signed'({1'b0, ratio}))) >>> B_FRAC;
            sy = (128'(signed'(vy)) * 128'(signed'({1'b0, ratio}))) >>> B_FRAC;
            r.x = CW'(longint'(p1x) + longint'(sx));
            r.y = CW'(longint'(p1y) + longint'(sy));
            r.offset = (CW+1)'((ratio * root) >> B_FRAC);
            r.ccase = CASE_INTERIOR;
        end
        return r;
    endfunction

    task automatic send_query(input logic [CW-1:0] p1x, input logic [CW-1:0] p1y,
                              input logic [CW-1:0] p2x, input logic [CW-1:0] p2y,
                              input logic [CW-1:0] qx, input logic [CW-1:0] qy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= IN_W'({qy, qx, p2y, p2x, p1y, p1x});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        nearest_q.insert(nearest_q.size(), project(p1x, p1y, p2x, p2y, qx, qy));
        @(negedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(4))
            0: return CW'($urandom);
            1: return CW'($urandom_range(255)) - CW'(128);
            2: return {1'b1, {(CW-1){1'b0}}} + CW'($urandom_range(15));
            3: return {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(15));
            default: return CW'($urandom_range(8191)) - CW'(4096);
        endcase
    endfunction

    // point at a random fraction (0 to 1.2) of the way from a to b
    function automatic logic [CW-1:0] along(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
        longint span;
        span = longint'(signed'(b)) - longint'(signed'(a));
        return a + CW'((longint'($urandom_range(1200)) * span) / 1000);
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        nearest_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[CW-1:0];
            got.y = m_tdata[2*CW-1:CW];
            got.offset = m_tdata[3*CW:2*CW];
            got.ccase = clamp_case_t'(m_tuser);
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = nearest_q.pop_front();
                if (got.x !== exp_r.x || got.y !== exp_r.y ||
                    got.offset !== exp_r.offset || got.ccase !== exp_r.ccase) begin
                    $display("%0t: mismatch exp x=%h y=%h off=%h case=%0d",
                             $time, exp_r.x, exp_r.y, exp_r.offset, exp_r.ccase);
                    $display("%0t:          got x=%h y=%h off=%h case=%0d",
                             $time, got.x, got.y, got.offset, got.ccase);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (nearest_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    task automatic test_directed();
        // degenerate segment
        send_query(CW'(0), CW'(0), CW'(0), CW'(0), CW'(0), CW'(0));
        // degenerate, far query
        send_query(CMAX, CMIN, CMAX, CMIN, CW'(5), CW'(7));
        // interior
        send_query(CW'(0), CW'(0), CW'(256), CW'(0), CW'(128), CW'(50));
        // exactly at second end
        send_query(CW'(0), CW'(0), CW'(256), CW'(0), CW'(256), CW'(0));
        // exactly at first end
        send_query(CW'(0), CW'(0), CW'(256), CW'(0), CW'(0), CW'(0));
        // before first end
        send_query(CW'(0), CW'(0), CW'(256), CW'(0), CW'(-5), CW'(3));
        // past second end
        send_query(CW'(0), CW'(0), CW'(256), CW'(0), CW'(900), CW'(3));
        // longest diagonal
        send_query(CMIN, CMIN, CMAX, CMAX, CW'(0), CW'(0));
        send_query(CMIN, CMIN, CMAX, CMAX, CW'(1), CW'(-1));
        send_query(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN);
        send_query(CMIN, CMAX, CMAX, CMIN, CW'(3), CW'(3));
        send_query(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN);
        send_query(CMAX, CW'(0), CMIN, CW'(0), CW'(0), CMAX);
        send_query(CW'(0), CMIN, CW'(0), CMAX, CMIN, CW'(1000));
        // negative vector steps
        send_query(CW'(-256), CW'(-256), CW'(256), CW'(256), CW'(100), CW'(-300));
        send_query(CW'(256), CW'(256), CW'(-256), CW'(-256), CW'(100), CW'(-299));
        send_query(CW'(-1), CW'(-1), CW'(0), CW'(0), CMIN, CMIN);
        send_query(CW'(1), CW'(2), CW'(3), CW'(5), CW'(2), CW'(3));
        send_query({CW{1'b1}}, CW'(0), CW'(0), {CW{1'b1}}, CMAX, CMAX);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [CW-1:0] p1x, p1y, p2x, p2y;
        for (int i = 0; i < count; i++) begin
            p1x = rand_coord(); p1y = rand_coord();
            if ($urandom_range(19) == 0) begin
                p2x = p1x; p2y = p1y;
            end else begin
                p2x = rand_coord(); p2y = rand_coord();
            end
            if ($urandom_range(3) == 0)
                send_query(p1x, p1y, p2x, p2y, rand_coord(), rand_coord());
            else
                // query near the segment so interior cases dominate
                send_query(p1x, p1y, p2x, p2y,
                           along(p1x, p2x) + CW'($urandom_range(64)) - CW'(32),
                           along(p1y, p2y) + CW'($urandom_range(64)) - CW'(32));
        end
    endtask

    task automatic test_stall_sender();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        send_idle_pct = 15; recv_idle_pct = 82;
        test_random(220);
        send_idle_pct = 82; recv_idle_pct = 15;
        test_random(220);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_stall_sender();
        test_random(200);
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && nearest_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[files.f]
design/cps_pkg.sv
design/cps_front.sv
design/cps_cell.sv
design/cps_back.sv
design/closest_point_on_segment_core.sv
tb/tb.sv
